// ===== rtl/olpd_pkg.sv =====
package olpd_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int SIZE_W       = 7;

  typedef enum logic [1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_DELETE    = 2'd2,
    REQ_READ      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    cap_req;
    logic    ins_front;
    logic    ins_back;
    logic    del_head;
    logic    del_tail;
    logic    idx_load_pos;
    logic    idx_clear;
    logic    shift_rd;
    logic    shift_mv;
    logic    ro_rd;
    logic    ro_out;
    logic    resp_load;
    status_t resp_status;
  } olpd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic pos_bad;
    logic pos_first;
    logic pos_last;
    logic idx_more;
    logic idx_last;
    logic out_free;
  } olpd_sts_t;

endpackage

// ===== rtl/olpd_ram.sv =====
module olpd_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/olpd_ctrl.sv =====
module olpd_ctrl
  import olpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  olpd_sts_t sts,
  output olpd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEL_RD,
    S_DEL_MV,
    S_RO_RD,
    S_RO_OUT,
    S_RESP
  } state_t;

  state_t  state, state_next;
  status_t resp_code, resp_code_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.resp_status = resp_code;
    state_next      = state;
    resp_code_next  = resp_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_req = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESP;
        case (sts.req)
          REQ_INS_FRONT: begin
            if (sts.full) begin
              resp_code_next = ST_FULL;
            end else begin
              cmd.ins_front  = 1'b1;
              resp_code_next = ST_OK;
            end
          end
          REQ_INS_BACK: begin
            if (sts.full) begin
              resp_code_next = ST_FULL;
            end else begin
              cmd.ins_back   = 1'b1;
              resp_code_next = ST_OK;
            end
          end
          REQ_DELETE: begin
            if (sts.empty) begin
              resp_code_next = ST_EMPTY;
            end else if (sts.pos_bad) begin
              resp_code_next = ST_RANGE;
            end else if (sts.pos_first) begin
              cmd.del_head   = 1'b1;
              resp_code_next = ST_OK;
            end else if (sts.pos_last) begin
              cmd.del_tail   = 1'b1;
              resp_code_next = ST_OK;
            end else begin
              cmd.idx_load_pos = 1'b1;
              state_next       = S_DEL_RD;
            end
          end
          REQ_READ: begin
            if (sts.empty) begin
              resp_code_next = ST_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = S_RO_RD;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DEL_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_DEL_MV;
      end
      S_DEL_MV: begin
        cmd.shift_mv = 1'b1;
        if (!sts.idx_more) begin
          cmd.del_tail   = 1'b1;
          resp_code_next = ST_OK;
          state_next     = S_RESP;
        end
      end
      S_RO_RD: begin
        cmd.ro_rd  = 1'b1;
        state_next = S_RO_OUT;
      end
      S_RO_OUT: begin
        if (sts.out_free) begin
          cmd.ro_out = 1'b1;
          state_next = sts.idx_last ? S_IDLE : S_RO_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resp_code <= ST_OK;
    end else begin
      state     <= state_next;
      resp_code <= resp_code_next;
    end
  end

endmodule

// ===== rtl/olpd_dp.sv =====
module olpd_dp
  import olpd_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  input  olpd_cmd_t                 cmd,
  output olpd_sts_t                 sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] element,
  output logic                      last,
  output logic [SIZE_W-1:0]         size
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SW    = CW + 1;

  // circular buffer: head points at the first element, count entries follow
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [1:0]            req_q;
  logic [VALUE_W-1:0]    value_q;
  logic [POS_W-1:0]      pos_q;

  logic [SW-1:0]         base_j, sum_j1, sum_j2, sum_tail;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]    ram_wdata, ram_rdata;
  logic                  out_free;

  assign base_j   = SW'(head) + SW'(idx);
  assign sum_j1   = base_j + SW'(1);
  assign sum_j2   = base_j + SW'(2);
  assign sum_tail = SW'(head) + SW'(count);

  assign out_free = !out_valid || !out_stall;

  assign sts.req       = req_t'(req_q);
  assign sts.full      = (count == CW'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.pos_bad   = (pos_q == '0) || (pos_q > POS_W'(count));
  assign sts.pos_first = (pos_q == POS_W'(1));
  assign sts.pos_last  = (pos_q == POS_W'(count));
  assign sts.idx_more  = ((SW'(idx) + SW'(2)) < SW'(count));
  assign sts.idx_last  = ((SW'(idx) + SW'(1)) == SW'(count));
  assign sts.out_free  = out_free;

  always_comb begin
    ram_we    = cmd.ins_front || cmd.ins_back || cmd.shift_mv;
    ram_wdata = cmd.shift_mv ? ram_rdata : value_q;
    if (cmd.ins_front) begin
      ram_waddr = head - AW'(1);
    end else if (cmd.ins_back) begin
      ram_waddr = sum_tail[AW-1:0];
    end else begin
      ram_waddr = base_j[AW-1:0];
    end
    ram_re = cmd.shift_rd || cmd.shift_mv || cmd.ro_rd;
    if (cmd.shift_rd) begin
      ram_raddr = sum_j1[AW-1:0];
    end else if (cmd.shift_mv) begin
      ram_raddr = sum_j2[AW-1:0];
    end else begin
      ram_raddr = base_j[AW-1:0];
    end
  end

  olpd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.ins_front) begin
        head  <= head - AW'(1);
        count <= count + CW'(1);
      end else if (cmd.ins_back) begin
        count <= count + CW'(1);
      end else if (cmd.del_head) begin
        head  <= head + AW'(1);
        count <= count - CW'(1);
      end else if (cmd.del_tail) begin
        count <= count - CW'(1);
      end
    end
  end

  // request capture and walk index
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_q   <= req_type;
      value_q <= value;
      pos_q   <= position;
    end
    if (cmd.idx_load_pos) begin
      idx <= CW'(pos_q - POS_W'(1));
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.shift_mv || cmd.ro_out) begin
      idx <= idx + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ro_out || cmd.resp_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ro_out) begin
      status  <= ST_OK;
      element <= ram_rdata;
      last    <= sts.idx_last;
      size    <= SIZE_W'(count);
    end else if (cmd.resp_load) begin
      status  <= cmd.resp_status;
      element <= '0;
      last    <= 1'b1;
      size    <= SIZE_W'(count);
    end
  end

endmodule

// ===== rtl/ordered_list_with_positional_delete_core.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   req_type, value, position
// out      output     out_valid/out_stall status, element, last, size
//
// States per request, from acceptance in S_IDLE back to S_IDLE, with no output stall:
// Insert, head/tail delete and out-of-range/empty/full requests: S_DECODE, then S_RESP.
// Delete in the middle: S_DECODE, S_DEL_RD, one S_DEL_MV per moved entry, then S_RESP.
// Read out: S_DECODE, then S_RO_RD and S_RO_OUT for each element through the RAM read port.
// Reset clears the list count and head pointer; stored entries need no clearing.
// out_stall holds the output register; the next request is taken once its result is loaded.
module ordered_list_with_positional_delete_core
  import olpd_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] element,
  output logic                      last,
  output logic [SIZE_W-1:0]         size
);

  olpd_cmd_t cmd;
  olpd_sts_t sts;

  // sequencing: decode, shift loop, read-out walk, response hand-off
  olpd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // circular buffer in RAM, count, walk index and output register
  olpd_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_type (req_type),
    .value    (value),
    .position (position),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .element  (element),
    .last     (last),
    .size     (size)
  );

endmodule
